// ===== design/strong_liar_count_defines.svh =====
// assertion macros for the strong liar counter
// expects clk and rst_n in the scope of each use
`ifndef STRONG_LIAR_COUNT_DEFINES_SVH
`define STRONG_LIAR_COUNT_DEFINES_SVH

// same-cycle implication
`define SLC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SLC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/slc_pkg.sv =====
// shared types for the strong liar counter
// no dependencies
`default_nettype none

package slc_pkg;

  // divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } slc_div_stat_t;

endpackage

`default_nettype wire

// ===== design/slc_ifs.sv =====
// valid/ready channel interfaces for candidate and result transactions
// no dependencies
`default_nettype none

interface slc_in_if #(parameter int W = 24);
  logic         valid;
  logic         ready;
  logic [W-1:0] candidate;

  modport source (output valid, output candidate, input ready);
  modport sink   (input valid, input candidate, output ready);
endinterface

interface slc_out_if #(parameter int W = 24);
  logic         valid;
  logic         ready;
  logic [W-1:0] liar_count;
  logic         is_prime;
  logic         invalid;

  modport source (output valid, output liar_count, output is_prime, output invalid,
                  input ready);
  modport sink   (input valid, input liar_count, input is_prime, input invalid,
                  output ready);
endinterface

`default_nettype wire

// ===== design/slc_div.sv =====
// restoring divider, one quotient bit per cycle, shared by trial division and gcd
// depends on slc_pkg
`default_nettype none

module slc_div import slc_pkg::*; #(
  parameter int W = 24
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [W-1:0]  dividend,
  input  logic [W-1:0]  divisor,
  output slc_div_stat_t stat,
  output logic [W-1:0]  quo,
  output logic [W-1:0]  rem
);

  localparam int CNTW = $clog2(W + 1);

  logic [W-1:0]    quo_r;
  logic [W-1:0]    rem_r;
  logic [W-1:0]    dvs_r;
  logic [CNTW-1:0] cnt_r;
  logic            busy_r;
  logic            done_r;
  logic [W:0]      shifted;
  logic [W:0]      diff;

  assign shifted = {rem_r, quo_r[W-1]};
  assign diff    = shifted - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(W);
        quo_r  <= dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        if (!diff[W]) begin
          rem_r <= diff[W-1:0];
          quo_r <= {quo_r[W-2:0], 1'b1};
        end else begin
          rem_r <= shifted[W-1:0];
          quo_r <= {quo_r[W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quo       = quo_r;
  assign rem       = rem_r;

endmodule

`default_nettype wire

// ===== design/strong_liar_count.sv =====
// channel    | dir | payload
// in_ch      | in  | candidate[NUM_BITS]
// out_ch     | out | liar_count[NUM_BITS], is_prime, invalid
//
// one candidate at a time; ready only while idle
// each trial division and each gcd step is one pass through the shared divider;
// even or small candidates skip the divider and go straight to the output register
// result sits in an output register; a stalled sink holds the sequencer
// synchronous active-low reset, no clearing pass
// top level: sequencer, multiplier and output register; depends on slc_pkg,
// slc_ifs, slc_div and strong_liar_count_defines.svh
`default_nettype none
`include "strong_liar_count_defines.svh"

module strong_liar_count import slc_pkg::*; #(
  parameter int NUM_BITS = 24
) (
  input  logic       clk,
  input  logic       rst_n,
  slc_in_if.sink     in_ch,
  slc_out_if.source  out_ch
);

  localparam int CW = $clog2(NUM_BITS + 1);
  localparam int DW = NUM_BITS + 2;

  typedef enum logic [3:0] {
    S_IDLE, S_USTRIP, S_CHECK, S_DIV, S_DIVWAIT, S_TZ, S_GCD, S_GCDWAIT,
    S_MUL, S_TAIL, S_FIN, S_TERM, S_FMUL, S_OUT
  } state_t;

  state_t              state_r;
  logic [NUM_BITS-1:0] rest_r, u_r, d_r, gprod_r, x_r, ga_r, gb_r, acc_r, res_r;
  logic [DW-1:0]       dsq_r;
  logic [CW-1:0]       w_r, v_r, cnt_r, e_r, k_r;
  logic                hit_r, tail_r, prm_r, inv_r;
  logic                div_start_r;
  logic [NUM_BITS-1:0] div_a_r, div_b_r;
  logic                out_valid_r, out_prm_r, out_inv_r;
  logic [NUM_BITS-1:0] out_cnt_r;

  slc_div_stat_t         div_stat;
  logic [NUM_BITS-1:0]   div_quo, div_rem;
  logic [NUM_BITS-1:0]   cand, mul_a;
  logic [2*NUM_BITS-1:0] prod;

  slc_div #(.W(NUM_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (div_a_r),
    .divisor  (div_b_r),
    .stat     (div_stat),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  assign cand  = in_ch.candidate;
  // one multiplier: gcd product update, then the final scale
  assign mul_a = (state_r == S_FMUL) ? acc_r + NUM_BITS'(1) : ga_r;
  assign prod  = mul_a * gprod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      div_start_r <= 1'b0;
      if (out_valid_r && out_ch.ready && state_r != S_OUT) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            if (cand < NUM_BITS'(3) || !cand[0]) begin
              res_r   <= '0;
              prm_r   <= 1'b0;
              inv_r   <= 1'b1;
              state_r <= S_OUT;
            end else begin
              u_r     <= cand - NUM_BITS'(1);
              rest_r  <= cand;
              d_r     <= NUM_BITS'(3);
              dsq_r   <= DW'(9);
              w_r     <= '0;
              v_r     <= CW'(NUM_BITS);
              cnt_r   <= '0;
              gprod_r <= NUM_BITS'(1);
              hit_r   <= 1'b0;
              tail_r  <= 1'b0;
              prm_r   <= 1'b0;
              inv_r   <= 1'b0;
              state_r <= S_USTRIP;
            end
          end
        end
        S_USTRIP: begin
          if (!u_r[0]) u_r <= u_r >> 1;
          else state_r <= S_CHECK;
        end
        S_CHECK: begin
          if (dsq_r <= {2'b00, rest_r}) state_r <= S_DIV;
          else state_r <= S_TAIL;
        end
        S_DIV: begin
          div_start_r <= 1'b1;
          div_a_r     <= rest_r;
          div_b_r     <= d_r;
          state_r     <= S_DIVWAIT;
        end
        S_DIVWAIT: begin
          if (div_stat.done) begin
            if (div_rem == '0) begin
              rest_r <= div_quo;
              cnt_r  <= cnt_r + CW'(1);
              if (!hit_r) begin
                // first hit on this divisor: fold it in as a new prime
                hit_r   <= 1'b1;
                x_r     <= d_r - NUM_BITS'(1);
                e_r     <= '0;
                state_r <= S_TZ;
              end else begin
                state_r <= S_DIV;
              end
            end else begin
              hit_r   <= 1'b0;
              d_r     <= d_r + NUM_BITS'(2);
              dsq_r   <= dsq_r + {d_r, 2'b00} + DW'(4);
              state_r <= S_CHECK;
            end
          end
        end
        S_TZ: begin
          if (!x_r[0]) begin
            x_r <= x_r >> 1;
            e_r <= e_r + CW'(1);
          end else begin
            if (e_r < v_r) v_r <= e_r;
            w_r     <= w_r + CW'(1);
            ga_r    <= u_r;
            gb_r    <= tail_r ? rest_r - NUM_BITS'(1) : d_r - NUM_BITS'(1);
            state_r <= S_GCD;
          end
        end
        S_GCD: begin
          if (gb_r == '0) begin
            state_r <= S_MUL;
          end else begin
            div_start_r <= 1'b1;
            div_a_r     <= ga_r;
            div_b_r     <= gb_r;
            state_r     <= S_GCDWAIT;
          end
        end
        S_GCDWAIT: begin
          if (div_stat.done) begin
            ga_r    <= gb_r;
            gb_r    <= div_rem;
            state_r <= S_GCD;
          end
        end
        S_MUL: begin
          gprod_r <= prod[NUM_BITS-1:0];
          state_r <= tail_r ? S_FIN : S_DIV;
        end
        S_TAIL: begin
          // leftover cofactor above one is the last prime
          if (rest_r > NUM_BITS'(1)) begin
            cnt_r   <= cnt_r + CW'(1);
            tail_r  <= 1'b1;
            x_r     <= rest_r - NUM_BITS'(1);
            e_r     <= '0;
            state_r <= S_TZ;
          end else begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (cnt_r == CW'(1)) begin
            res_r   <= '0;
            prm_r   <= 1'b1;
            state_r <= S_OUT;
          end else begin
            acc_r   <= '0;
            k_r     <= v_r;
            state_r <= S_TERM;
          end
        end
        S_TERM: begin
          // geometric sum of 2^(k*w) for k below v
          if (k_r == '0) begin
            state_r <= S_FMUL;
          end else begin
            acc_r <= (acc_r << w_r) | NUM_BITS'(1);
            k_r   <= k_r - CW'(1);
          end
        end
        S_FMUL: begin
          res_r   <= prod[NUM_BITS-1:0];
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_cnt_r   <= res_r;
            out_prm_r   <= prm_r;
            out_inv_r   <= inv_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.liar_count = out_cnt_r;
  assign out_ch.is_prime   = out_prm_r;
  assign out_ch.invalid    = out_inv_r;

  `SLC_ASSERT_IMP(a_prime_zero, out_valid_r && out_prm_r,
                  out_cnt_r == '0 && !out_inv_r, "prime result with count or invalid flag")
  `SLC_ASSERT_IMP(a_inv_zero, out_valid_r && out_inv_r,
                  out_cnt_r == '0 && !out_prm_r, "invalid result with count or prime flag")
  `SLC_ASSERT_IMP(a_div_owner, div_stat.busy,
                  state_r == S_DIVWAIT || state_r == S_GCDWAIT, "divider busy outside a wait state")
  `SLC_ASSERT_NXT(a_busy_after_take, in_ch.valid && in_ch.ready,
                  !in_ch.ready, "ready right after a transaction")

endmodule

`default_nettype wire

// ===== tb/tb_strong_liar_count.sv =====
// self-checking testbench for strong_liar_count: directed and random candidates
// with random idling on both channels, scoreboard with its own liar-count predictor
// depends on slc_pkg, slc_ifs and the strong_liar_count design files
`default_nettype none

module tb_strong_liar_count;
  import slc_pkg::*;

  localparam int W           = 24;
  localparam int NUM_RANDOM  = 270;
  localparam int WATCHDOG    = 400000;
  localparam int LONG_HOLD   = 400;
  localparam int HOLD_AT     = 30;

  typedef logic [W-1:0] value_t;

  typedef struct packed {
    value_t liar_count;
    logic   is_prime;
    logic   invalid;
  } liar_result_t;

  class liar_scoreboard;
    liar_result_t pending[$];
    int           errors = 0;

    function automatic longint unsigned gcd(longint unsigned a, longint unsigned b);
      longint unsigned r;
      while (b != 0) begin
        r = a % b;
        a = b;
        b = r;
      end
      return a;
    endfunction

    function automatic longint unsigned twos_in(longint unsigned x);
      longint unsigned e = 0;
      if (x == 0) return 0;
      while (x[0] == 1'b0) begin
        x = x >> 1;
        e++;
      end
      return e;
    endfunction

    function automatic liar_result_t predict_liars(value_t cand);
      liar_result_t    res = '0;
      longint unsigned n = cand;
      longint unsigned rest, d, u, w, v, factors, gprod, term, e;
      if (n < 3 || n[0] == 1'b0) begin
        res.invalid = 1'b1;
        return res;
      end
      u = n - 1;
      while (u[0] == 1'b0) u = u >> 1;
      rest = n;
      w = 0;
      v = W;
      factors = 0;
      gprod = 1;
      for (d = 3; d * d <= rest; d += 2) begin
        if (rest % d == 0) begin
          e = twos_in(d - 1);
          w++;
          if (e < v) v = e;
          gprod *= gcd(u, d - 1);
          while (rest % d == 0) begin
            rest /= d;
            factors++;
          end
        end
      end
      // whatever is left above the square root is one more prime
      if (rest > 1) begin
        e = twos_in(rest - 1);
        w++;
        if (e < v) v = e;
        gprod *= gcd(u, rest - 1);
        factors++;
      end
      if (factors == 1) begin
        res.is_prime = 1'b1;
        return res;
      end
      term = 1 + (((64'd1 << (w * v)) - 1) / ((64'd1 << w) - 1));
      res.liar_count = value_t'(term * gprod);
      return res;
    endfunction

    function void note_candidate(value_t cand);
      pending.push_back(predict_liars(cand));
    endfunction

    function void check_result(value_t liar_count, logic is_prime, logic invalid);
      liar_result_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result liar_count=%0d is_prime=%0b invalid=%0b",
                 $time, liar_count, is_prime, invalid);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (liar_count !== exp_r.liar_count) begin
        $display("%0t: liar_count expected %0d actual %0d", $time, exp_r.liar_count,
                 liar_count);
        errors++;
      end
      if (is_prime !== exp_r.is_prime) begin
        $display("%0t: is_prime expected %0b actual %0b", $time, exp_r.is_prime, is_prime);
        errors++;
      end
      if (invalid !== exp_r.invalid) begin
        $display("%0t: invalid expected %0b actual %0b", $time, exp_r.invalid, invalid);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  slc_in_if  #(.W(W)) in_ch ();
  slc_out_if #(.W(W)) out_ch ();

  strong_liar_count #(.NUM_BITS(W)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  liar_scoreboard sb = new();

  int  idle_cycles = 0;
  bit  no_gaps = 1'b0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.candidate = '0;
    out_ch.ready = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // sender: one transaction per call, valid stays high across back-to-back items
  task automatic send_candidate(value_t cand);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.candidate <= cand;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_candidate(cand);
  endtask

  function automatic value_t random_candidate();
    int     pick;
    value_t c;
    pick = $urandom_range(0, 99);
    // keep most values small so trial division stays short
    if (pick < 80)
      c = value_t'($urandom_range(0, 16383));
    else if (pick < 97)
      c = value_t'($urandom_range(1, 255) * $urandom_range(1, 4095));
    else
      c = value_t'($urandom);
    if ($urandom_range(0, 9) != 0) c[0] = 1'b1;
    return c;
  endfunction

  // receiver with random stalls and one long hold-off
  initial begin
    int  stall;
    int  results = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = (results == HOLD_AT) ? LONG_HOLD : $urandom_range(0, 13);
      if (no_gaps && results != HOLD_AT) stall = 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      sb.check_result(out_ch.liar_count, out_ch.is_prime, out_ch.invalid);
      results++;
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    value_t directed[$] = '{
      24'd0, 24'd1, 24'd2, 24'd3, 24'd4, 24'd5, 24'd9, 24'd15, 24'd21, 24'd25,
      24'd27, 24'd91, 24'd561, 24'd1105, 24'd2047, 24'd3481, 24'd15841,
      24'hFFFFFF, 24'hFFFFFE, 24'h800001, 24'hAAAAAB, 24'h555555, 24'd16769023,
      24'd4005001
    };
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) send_candidate(directed[i]);
    for (int i = 0; i < NUM_RANDOM; i++) begin
      no_gaps = (i >= 100 && i < 140);
      send_candidate(random_candidate());
    end
    no_gaps = 1'b0;
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire

// ===== strong_liar_count.f =====
+incdir+design
design/slc_pkg.sv
design/slc_ifs.sv
design/slc_div.sv
design/strong_liar_count.sv
tb/tb_strong_liar_count.sv
